/* hdl/trjd_pkg.sv */
// Shared types, constants and table functions for the touch-ring joypad decoder.
// No dependencies; imported by every module of the block.
package trjd_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_MASK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_CODE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_CODE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CODE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CODE     = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_TOUCH_MASK     = 16'h01FF;
  localparam logic [7:0]  RST_IDLE_THRESHOLD = 8'd10;
  localparam logic [7:0]  RST_REPEAT_PERIOD  = 8'd5;
  localparam logic [3:0]  RST_UP_CODE        = 4'd1;
  localparam logic [3:0]  RST_DOWN_CODE      = 4'd2;
  localparam logic [3:0]  RST_LEFT_CODE      = 4'd4;
  localparam logic [3:0]  RST_RIGHT_CODE     = 4'd8;

  // Ring regions by position on the ring
  localparam logic [2:0] RGN_NONE   = 3'd0;
  localparam logic [2:0] RGN_TOP    = 3'd1;
  localparam logic [2:0] RGN_RIGHT  = 3'd2;
  localparam logic [2:0] RGN_BOTTOM = 3'd3;
  localparam logic [2:0] RGN_LEFT   = 3'd4;

  // Status word masks
  localparam logic [8:0] SW_KEEP_HIGH = 9'h1F0;  // drop the direction code
  localparam logic [8:0] SW_KEEP_LOW  = 9'h01F;  // drop the repeat pulses
  localparam logic [8:0] SW_CENTRE    = 9'h010;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] touch_mask;
    logic [7:0]  idle_threshold;
    logic [7:0]  repeat_period;
    logic [3:0]  up_code;
    logic [3:0]  down_code;
    logic [3:0]  left_code;
    logic [3:0]  right_code;
  } cfg_t;

  // Fixed ring pattern to region table
  function automatic logic [2:0] ring_region(input logic [7:0] ring);
    logic [2:0] rgn;
    unique case (ring) inside
      8'h01, 8'h80, 8'h81, 8'h83, 8'hC1, 8'hC3: rgn = RGN_TOP;
      8'h02, 8'h04, 8'h06, 8'h07, 8'h0D, 8'h0E: rgn = RGN_RIGHT;
      8'h08, 8'h10, 8'h18, 8'h1C, 8'h38, 8'h3C: rgn = RGN_BOTTOM;
      8'h20, 8'h40, 8'h60, 8'h70, 8'hE0, 8'hF0: rgn = RGN_LEFT;
      default:                                  rgn = RGN_NONE;
    endcase
    return rgn;
  endfunction

  // Repeat pulse bit for lane k (region minus one)
  function automatic logic [8:0] pulse_bit(input logic [1:0] k);
    logic [8:0] b;
    unique case (k)
      2'd0:    b = 9'h040;
      2'd1:    b = 9'h100;
      2'd2:    b = 9'h020;
      default: b = 9'h080;
    endcase
    return b;
  endfunction

endpackage

/* hdl/trjd_region.sv */
// Ring decoder: maps the eight ring bits of the status word to a region.
// Depends on trjd_pkg (ring_region table).
module trjd_region (
  input  logic [7:0] ring,
  output logic [2:0] region
);
  import trjd_pkg::*;

  // Look up the fixed pattern table
  assign region = ring_region(ring);

endmodule

/* hdl/trjd_state.sv */
// Decoder state and per-beat update: latches, steady count and auto-repeat.
// Depends on trjd_pkg (cfg_t, region codes, masks, pulse_bit).
module trjd_state (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [15:0]        stage_status,
  input  logic               wheel_moved,
  input  logic [2:0]         region,
  input  trjd_pkg::cfg_t     cfg,
  output logic [8:0]         status_nxt
);
  import trjd_pkg::*;

  logic       touch_down_r, touch_down_nxt;
  logic [7:0] steady_r, steady_nxt;
  logic       found_r, found_nxt;
  logic       shown_r, shown_nxt;
  logic [3:0] pend_r, pend_nxt;
  logic [7:0] rcnt_r [4];
  logic [7:0] rcnt_nxt [4];
  logic [7:0] gap_r, gap_nxt;
  logic       centre_r, centre_nxt;
  logic [8:0] sw_r;

  // Work out the next state and status word for one beat
  always_comb begin
    logic [8:0] sw;
    logic [3:0] code;
    logic [1:0] k;
    logic [7:0] rinc;
    logic       touched;

    touch_down_nxt = touch_down_r;
    steady_nxt     = steady_r;
    found_nxt      = found_r;
    shown_nxt      = shown_r;
    pend_nxt       = pend_r;
    rcnt_nxt       = rcnt_r;
    gap_nxt        = gap_r;
    centre_nxt     = centre_r;
    sw             = sw_r;
    code           = '0;
    k              = 2'(region - 3'd1);
    rinc           = rcnt_r[k] + 8'd1;
    touched        = |(stage_status & cfg.touch_mask);

    if (touched) begin
      // Track touch-down from ring and centre bits
      if (stage_status[7:0] != 8'd0) begin
        touch_down_nxt = 1'b1;
      end else if (stage_status[8]) begin
        touch_down_nxt = 1'b0;
      end

      // Count steady beats and latch a direction
      if (!wheel_moved && !centre_r) begin
        steady_nxt = (steady_r == COUNT_MAX) ? steady_r : steady_r + 8'd1;
        if (steady_nxt > cfg.idle_threshold && !found_r) begin
          unique case (region)
            RGN_BOTTOM: code = cfg.up_code;
            RGN_RIGHT:  code = cfg.right_code;
            RGN_TOP:    code = cfg.down_code;
            RGN_LEFT:   code = cfg.left_code;
            default:    code = '0;
          endcase
          if (region != RGN_NONE) begin
            sw        = {5'd0, code};
            shown_nxt = 1'b1;
            found_nxt = 1'b1;
          end
        end
        if (found_nxt && region == RGN_NONE && shown_nxt) begin
          shown_nxt = 1'b0;
          sw        = sw & SW_KEEP_HIGH;
        end
      end else begin
        sw         = sw & SW_KEEP_HIGH;
        steady_nxt = '0;
      end

      // Auto-repeat while a region is held
      if (steady_nxt > cfg.idle_threshold && found_nxt) begin
        if (region != RGN_NONE) begin
          sw = sw & SW_KEEP_LOW;
          if (pend_r[k]) begin
            pend_nxt[k] = 1'b0;
            sw          = sw | pulse_bit(k);
          end else begin
            if (rinc >= gap_r) begin
              rinc        = '0;
              pend_nxt[k] = 1'b1;
              gap_nxt     = cfg.repeat_period;
            end
            rcnt_nxt[k] = rinc;
          end
        end
      end else begin
        pend_nxt = '0;
        for (int i = 0; i < 4; i++) begin
          rcnt_nxt[i] = '0;
        end
        gap_nxt = '0;
        sw      = sw & SW_KEEP_LOW;
      end

      // Centre button
      if (stage_status[8] && !wheel_moved) begin
        sw         = touch_down_nxt ? '0 : SW_CENTRE;
        centre_nxt = 1'b1;
      end else begin
        sw = sw & ~SW_CENTRE;
      end
    end else begin
      // Release: drop latches and status, keep repeat state
      steady_nxt = '0;
      found_nxt  = 1'b0;
      shown_nxt  = 1'b0;
      centre_nxt = 1'b0;
      sw         = '0;
    end

    status_nxt = sw;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_down_r <= 1'b0;
      steady_r     <= '0;
      found_r      <= 1'b0;
      shown_r      <= 1'b0;
      pend_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        rcnt_r[i] <= '0;
      end
      gap_r        <= '0;
      centre_r     <= 1'b0;
      sw_r         <= '0;
    end else if (step_en) begin
      touch_down_r <= touch_down_nxt;
      steady_r     <= steady_nxt;
      found_r      <= found_nxt;
      shown_r      <= shown_nxt;
      pend_r       <= pend_nxt;
      rcnt_r       <= rcnt_nxt;
      gap_r        <= gap_nxt;
      centre_r     <= centre_nxt;
      sw_r         <= status_nxt;
    end
  end

endmodule

/* hdl/touch_ring_joypad_decoder.sv */
// Top level of the touch-ring joypad decoder: config registers, output register.
// Depends on trjd_pkg, trjd_region and trjd_state.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat carries a 16-bit sensor
//   interrupt word (ring in bits 0-7, centre in bit 8) and a wheel-moved flag.
//   Output channel (out_valid/out_ready): one 9-bit button status per input
//   beat, in order.
//   Config port: cfg_we writes cfg_data to register cfg_index (0 touch mask,
//   1 idle threshold, 2 repeat period, 3-6 up/down/left/right codes) in the
//   same cycle; unknown indexes are ignored. Write only while idle.
//   Latency: the result is valid the cycle after the input beat is taken.
//   Throughput: one beat per cycle unless stalled; the decoder state updates
//   in a single pass of logic from the accepted beat into the output register.
//   Stall: while out_valid is high and out_ready low, in_ready is low and the
//   held result stays put; a new beat is taken in the same cycle the held
//   result leaves.
//   Reset (rst_n low, synchronous): registers return to defaults, all
//   decoder state clears and the output register empties.
module touch_ring_joypad_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       in_stage_status,
  input  logic                              in_wheel_moved,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [8:0]                        out_button_status,
  input  logic                              cfg_we,
  input  logic [trjd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trjd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import trjd_pkg::*;

  cfg_t       cfg_r;
  logic       accept;
  logic [2:0] region;
  logic [8:0] status_nxt;
  logic       out_valid_r;
  logic [8:0] out_status_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_mask     <= RST_TOUCH_MASK;
      cfg_r.idle_threshold <= RST_IDLE_THRESHOLD;
      cfg_r.repeat_period  <= RST_REPEAT_PERIOD;
      cfg_r.up_code        <= RST_UP_CODE;
      cfg_r.down_code      <= RST_DOWN_CODE;
      cfg_r.left_code      <= RST_LEFT_CODE;
      cfg_r.right_code     <= RST_RIGHT_CODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOUCH_MASK:     cfg_r.touch_mask     <= cfg_data;
        CFG_IDLE_THRESHOLD: cfg_r.idle_threshold <= cfg_data[7:0];
        CFG_REPEAT_PERIOD:  cfg_r.repeat_period  <= cfg_data[7:0];
        CFG_UP_CODE:        cfg_r.up_code        <= cfg_data[3:0];
        CFG_DOWN_CODE:      cfg_r.down_code      <= cfg_data[3:0];
        CFG_LEFT_CODE:      cfg_r.left_code      <= cfg_data[3:0];
        CFG_RIGHT_CODE:     cfg_r.right_code     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Take a beat whenever the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  trjd_region u_region (
    .ring   (in_stage_status[7:0]),
    .region (region)
  );

  trjd_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (accept),
    .stage_status (in_stage_status),
    .wheel_moved  (in_wheel_moved),
    .region       (region),
    .cfg          (cfg_r),
    .status_nxt   (status_nxt)
  );

  // Output register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_button_status = out_status_r;

`ifndef SYNTH
  // Every accepted beat produces a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  // At most one repeat pulse per result
  a_pulse_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_button_status[8:5]))
    else $error("more than one repeat pulse");

  // Centre button excludes every other bit
  a_centre_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_button_status[4]) |->
      (out_button_status[3:0] == 4'd0 && out_button_status[8:5] == 4'd0))
    else $error("centre bit shown with other buttons");

  // Untouched beat gives an all-zero status
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_stage_status & cfg_r.touch_mask) == 16'd0)) |=>
      (out_button_status == 9'd0))
    else $error("untouched beat gave nonzero status");
`endif

endmodule

/* dv/touch_ring_joypad_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for touch_ring_joypad_decoder: directed and random sensor words.
// Depends on trjd_pkg and the decoder RTL; tracks the joypad state to predict every status beat.
module touch_ring_joypad_decoder_tb;
  import trjd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam logic [8:0] SW_KEEP_NO_CENTRE = 9'h1EF;
  localparam logic [8:0] PULSE_TOP    = 9'h040;
  localparam logic [8:0] PULSE_RIGHT  = 9'h100;
  localparam logic [8:0] PULSE_BOTTOM = 9'h020;
  localparam logic [8:0] PULSE_LEFT   = 9'h080;
  localparam int MAX_IDLE = 17;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [15:0] in_stage_status;
  logic in_wheel_moved;
  logic out_valid, out_ready;
  logic [8:0] out_button_status;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Ring patterns, six per region, in region order top, right, bottom, left
  logic [7:0] ring_pat [24] = '{
    8'h01, 8'h80, 8'h81, 8'h83, 8'hC1, 8'hC3,
    8'h02, 8'h04, 8'h06, 8'h07, 8'h0D, 8'h0E,
    8'h08, 8'h10, 8'h18, 8'h1C, 8'h38, 8'h3C,
    8'h20, 8'h40, 8'h60, 8'h70, 8'hE0, 8'hF0
  };

  // Register copy and joypad state of the prediction
  cfg_t       cur_cfg;
  logic       td;
  logic [2:0] rgn;
  logic [7:0] steady;
  logic       found, shown, centre;
  logic [3:0] pend;
  logic [7:0] rep_cnt [4];
  logic [7:0] gap_len;
  logic [8:0] sw;

  logic [8:0] status_q [$];
  int fails = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int regs_written = 0;
  int holds_done = 0;
  int hold_req = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;

  touch_ring_joypad_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stage_status   (in_stage_status),
    .in_wheel_moved    (in_wheel_moved),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_button_status (out_button_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Look up the region of a ring pattern; unlisted patterns give none
  function automatic logic [2:0] ring_to_region(input logic [7:0] ring);
    logic [2:0] r;
    r = RGN_NONE;
    for (int i = 0; i < 24; i++) begin
      if (ring_pat[i] == ring) r = 3'(int'(RGN_TOP) + i / 6);
    end
    return r;
  endfunction

  // Advance the joypad state by one sensor word and return the status it shows
  function automatic logic [8:0] joypad_next(input logic [15:0] st, input logic mv);
    logic [3:0] code;
    logic hit;
    int k;
    if ((st & cur_cfg.touch_mask) != 0) begin
      if (st[7:0] != 0) td = 1'b1;
      else if (st[8:0] == 9'h100) td = 1'b0;
      rgn = ring_to_region(st[7:0]);

      // Count steady touches, latch a direction once past the threshold
      if (!mv && !centre) begin
        if (steady != COUNT_MAX) steady = steady + 8'd1;
        if (steady > cur_cfg.idle_threshold && !found) begin
          hit = 1'b1;
          code = '0;
          case (rgn)
            RGN_BOTTOM: code = cur_cfg.up_code;
            RGN_RIGHT:  code = cur_cfg.right_code;
            RGN_TOP:    code = cur_cfg.down_code;
            RGN_LEFT:   code = cur_cfg.left_code;
            default:    hit = 1'b0;
          endcase
          if (hit) begin
            sw = {5'b0, code};
            shown = 1'b1;
            found = 1'b1;
          end
        end
        if (found && rgn == RGN_NONE && shown) begin
          shown = 1'b0;
          sw = sw & SW_KEEP_HIGH;
        end
      end else begin
        sw = sw & SW_KEEP_HIGH;
        steady = '0;
      end

      // Auto-repeat: arm on the held item, emit on the next one
      if (steady > cur_cfg.idle_threshold && found) begin
        if (rgn != RGN_NONE) begin
          k = int'(rgn - RGN_TOP);
          sw = sw & SW_KEEP_LOW;
          if (pend[k]) begin
            pend[k] = 1'b0;
            case (rgn)
              RGN_TOP:   sw = sw | PULSE_TOP;
              RGN_RIGHT: sw = sw | PULSE_RIGHT;
              RGN_BOTTOM: sw = sw | PULSE_BOTTOM;
              default:   sw = sw | PULSE_LEFT;
            endcase
          end else begin
            rep_cnt[k] = rep_cnt[k] + 8'd1;
            if (rep_cnt[k] >= gap_len) begin
              rep_cnt[k] = '0;
              pend[k] = 1'b1;
              gap_len = cur_cfg.repeat_period;
            end
          end
        end
      end else begin
        pend = '0;
        foreach (rep_cnt[i]) rep_cnt[i] = '0;
        gap_len = '0;
        sw = sw & SW_KEEP_LOW;
      end

      // Centre button overrides the whole word
      if (st[8] && !mv) begin
        sw = td ? 9'h000 : SW_CENTRE;
        centre = 1'b1;
      end else begin
        sw = sw & SW_KEEP_NO_CENTRE;
      end
    end else begin
      steady = '0;
      found = 1'b0;
      shown = 1'b0;
      centre = 1'b0;
      sw = '0;
    end
    return sw;
  endfunction

  // Offer one sensor word, hold it until taken, then queue its expected status
  task automatic send_beat(input logic [15:0] st, input logic mv);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      in_stage_status = 16'($urandom);
      in_wheel_moved = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_stage_status = st;
    in_wheel_moved = mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    status_q.push_back(joypad_next(st, mv));
    items_sent++;
  endtask

  // Drop valid and wait for every queued status beat, with a bound
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (status_q.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      CFG_TOUCH_MASK:     cur_cfg.touch_mask = data;
      CFG_IDLE_THRESHOLD: cur_cfg.idle_threshold = data[7:0];
      CFG_REPEAT_PERIOD:  cur_cfg.repeat_period = data[7:0];
      CFG_UP_CODE:        cur_cfg.up_code = data[3:0];
      CFG_DOWN_CODE:      cur_cfg.down_code = data[3:0];
      CFG_LEFT_CODE:      cur_cfg.left_code = data[3:0];
      CFG_RIGHT_CODE:     cur_cfg.right_code = data[3:0];
      default: ;
    endcase
    regs_written++;
  endtask

  // Write all registers with junk above each width, then hit the unused index
  task automatic load_settings(input logic [15:0] mask, input logic [7:0] thr,
                               input logic [7:0] period, input logic [3:0] up,
                               input logic [3:0] dn, input logic [3:0] lf,
                               input logic [3:0] rt);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_TOUCH_MASK, mask);
    write_reg(CFG_IDLE_THRESHOLD, {junk[15:8], thr});
    write_reg(CFG_REPEAT_PERIOD, {junk[7:0], period});
    write_reg(CFG_UP_CODE, {junk[15:4], up});
    write_reg(CFG_DOWN_CODE, {junk[11:0], dn});
    write_reg(CFG_LEFT_CODE, {junk[14:3], lf});
    write_reg(CFG_RIGHT_CODE, {junk[13:2], rt});
    write_reg(CFG_IDX_SPARE, junk);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Hold one pattern of each region for len items, untouched word after each
  task automatic region_holds(input int len);
    logic [15:0] upper;
    logic [7:0] pat;
    for (int r = 0; r < 4; r++) begin
      pat = ring_pat[r * 6 + $urandom_range(0, 5)];
      repeat (len) begin
        upper = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
        send_beat({upper[15:9], ($urandom_range(0, 5) == 0), pat}, 1'b0);
      end
      send_beat(16'h0000, 1'b0);
    end
  endtask

  // One touch: mostly a held pattern, with noise, centre hits and wheel moves
  task automatic touch_sequence();
    int len;
    logic [15:0] upper;
    logic [7:0] pat, ring;
    logic ctr, mv;
    len = cur_cfg.idle_threshold + 3 * cur_cfg.repeat_period + 6;
    len = $urandom_range(1, (len > 48) ? 48 : len);
    pat = ring_pat[$urandom_range(0, 23)];
    repeat (len) begin
      if ($urandom_range(0, 29) == 0) pat = ring_pat[$urandom_range(0, 23)];
      ring = ($urandom_range(0, 14) == 0) ? 8'($urandom) : pat;
      ctr = ($urandom_range(0, 19) == 0);
      mv = ($urandom_range(0, 24) == 0);
      upper = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
      send_beat({upper[15:9], ctr, ring}, mv);
    end
    repeat ($urandom_range(1, 2)) begin
      upper = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
      send_beat({upper[15:9], 9'h000}, 1'($urandom));
    end
  endtask

  // Extremes of the word, centre cases, then a held press up to its pulses
  task automatic test_directed();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_beat(16'h0000, 1'b0);
    send_beat(16'hFE00, 1'b0);
    send_beat(16'h0100, 1'b0);
    send_beat(16'h0101, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h00FF, 1'b1);
    send_beat(16'hFFFF, 1'b1);
    repeat (13) send_beat(16'h0008, 1'b0);
    send_beat(16'h00FF, 1'b0);
    send_beat(16'h8080, 1'b0);
    send_beat(16'h0000, 1'b0);
  endtask

  // Walk register extremes: zero and maximum threshold and period, full, empty and partial masks
  task automatic test_register_sweep();
    drain_results();
    load_settings(16'hFFFF, 8'd0, 8'd0, 4'hF, 4'h0, 4'h5, 4'hA);
    region_holds(5);
    drain_results();
    load_settings(16'h0000, 8'd3, 8'd1, 4'h3, 4'hC, 4'h6, 4'h9);
    region_holds(3);
    drain_results();
    load_settings(16'h0100, 8'd255, 8'd255, RST_UP_CODE, RST_DOWN_CODE,
                  RST_LEFT_CODE, RST_RIGHT_CODE);
    region_holds(3);
    drain_results();
    load_settings(16'h00FF, 8'd1, 8'd1, 4'h8, 4'h4, 4'h2, 4'h1);
    region_holds(6);
  endtask

  // Hold long enough for the steady count to saturate, no idling either side
  task automatic test_steady_saturation();
    logic [15:0] upper;
    drain_results();
    load_settings(RST_TOUCH_MASK, 8'd254, 8'd2, RST_UP_CODE, RST_DOWN_CODE,
                  RST_LEFT_CODE, RST_RIGHT_CODE);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (300) begin
      upper = 16'($urandom);
      send_beat({upper[15:9], 9'h018}, 1'b0);
    end
    send_beat(16'h0000, 1'b0);
  endtask

  // Stall the output for a long stretch while words keep coming back to back
  task automatic test_output_stall();
    drain_results();
    load_settings(RST_TOUCH_MASK, RST_IDLE_THRESHOLD, RST_REPEAT_PERIOD, RST_UP_CODE,
                  RST_DOWN_CODE, RST_LEFT_CODE, RST_RIGHT_CODE);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    hold_req = 80;
    repeat (30) send_beat(16'h0081, 1'b0);
  endtask

  // Random touches in chunks, each under fresh register values and idle mix
  task automatic test_random_touches();
    int stop_at;
    logic [31:0] r;
    logic [15:0] mask;
    logic [7:0] thr, period;
    for (int chunk = 0; chunk < 6; chunk++) begin
      drain_results();
      r = $urandom;
      mask = ($urandom_range(0, 4) == 0) ? r[15:0] : {r[15:9], 9'h1FF};
      thr = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12));
      period = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
      load_settings(mask, thr, period, r[19:16], r[23:20], r[27:24], r[31:28]);
      send_idle = (chunk % 3) != 1;
      recv_idle = (chunk % 3) != 2;
      stop_at = items_sent + 135;
      while (items_sent < stop_at) touch_sequence();
    end
  endtask

  // Output side: random stall before each beat, or a requested long hold-off
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
        holds_done++;
      end else begin
        stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid && hold_req == 0) @(posedge clk);
    end
  end

  // Compare each status beat with the oldest expectation
  always @(posedge clk) begin : check_status
    logic [8:0] want;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (status_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected status beat, expected none, got %03h",
                 $time, out_button_status);
      end else begin
        want = status_q.pop_front();
        if (out_button_status !== want) begin
          fails++;
          $display("%0t: button_status mismatch, expected %03h, got %03h",
                   $time, want, out_button_status);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stage_status = '0;
    in_wheel_moved = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_cfg = '{RST_TOUCH_MASK, RST_IDLE_THRESHOLD, RST_REPEAT_PERIOD, RST_UP_CODE,
                RST_DOWN_CODE, RST_LEFT_CODE, RST_RIGHT_CODE};
    td = 1'b0;
    rgn = RGN_NONE;
    steady = '0;
    found = 1'b0;
    shown = 1'b0;
    centre = 1'b0;
    pend = '0;
    foreach (rep_cnt[i]) rep_cnt[i] = '0;
    gap_len = '0;
    sw = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_sweep();
    test_steady_saturation();
    test_output_stall();
    test_random_touches();
    drain_results();

    if (status_q.size() != 0) begin
      fails += status_q.size();
      $display("%0t: %0d expected status beats never arrived", $time, status_q.size());
    end
    $display("Covered %0d sensor words and %0d status beats, %0d register writes,",
             items_sent, beats_checked, regs_written);
    $display("%0d long output hold-offs, %0d failures", holds_done, fails);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
